// ===== src/mslr_pkg.sv =====
`timescale 1ns / 1ps

package mslr_pkg;

    // Operation codes carried on func
    typedef enum logic [2:0] {
        FUNC_OPEN       = 3'd0,
        FUNC_CLOSE      = 3'd1,
        FUNC_SET_RATE   = 3'd2,
        FUNC_SET_TARGET = 3'd3,
        FUNC_JUMP       = 3'd4,
        FUNC_STEP       = 3'd5,
        FUNC_QUERY      = 3'd6
    } func_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_UNUSED = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    localparam int VALUE_W = 32;
    localparam int RATE_W  = 31;

    // One channel's stored state
    typedef struct packed {
        logic signed [VALUE_W-1:0] cur;
        logic signed [VALUE_W-1:0] tgt;
        logic [RATE_W-1:0]         rate;
    } slot_row_t;

endpackage

// ===== src/mslr_ramp.sv =====
`timescale 1ns / 1ps

module mslr_ramp
    import mslr_pkg::*;
(
    input  slot_row_t                 row,
    output logic signed [VALUE_W-1:0] next_cur
);

    logic signed [VALUE_W:0] diff;
    logic [VALUE_W:0]        mag;
    logic [VALUE_W:0]        amt;
    logic [VALUE_W:0]        rate_ext;
    logic [VALUE_W:0]        sum;

    // 33-bit difference never overflows
    assign diff     = {row.tgt[VALUE_W-1], row.tgt} - {row.cur[VALUE_W-1], row.cur};
    assign mag      = diff[VALUE_W] ? (~diff + 1'b1) : diff;
    assign rate_ext = (VALUE_W+1)'(row.rate);
    assign amt      = (mag > rate_ext) ? rate_ext : mag;
    assign sum      = diff[VALUE_W] ? ({row.cur[VALUE_W-1], row.cur} - amt)
                                    : ({row.cur[VALUE_W-1], row.cur} + amt);
    // result lies between cur and tgt, so the low 32 bits are exact
    assign next_cur = sum[VALUE_W-1:0];

endmodule

// ===== src/multichannel_slew_rate_limiter.sv =====
`timescale 1ns / 1ps

// Multichannel slew-rate limiter: a pool of SLOTS ramp channels.
// Request channel: func, slot and operand are taken at a rising edge with
//   start high and busy low. busy is held low, so a request may be issued
//   in every cycle.
// Result channel: value, opened_slot, at_target and status appear for one
//   cycle with done high. The receiver cannot stall; every request yields
//   exactly one result, in request order.
// Result path: a request taken is held in the stage-1 registers (row read),
//   then computed in stage 2 and registered as the result with done high.
// Throughput: one request per cycle, set by the single write port of the
//   channel row memory and a one-stage read with write bypass.
// Pipeline:
//   stage 1 - decode slot, read the addressed channel row (bypassing the
//             row being written by stage 2 in the same cycle);
//   stage 2 - priority-encode the lowest free channel for open, check the
//             used mark, apply the operation, write the row back and
//             register the result.
// Reset: all channels marked unused, pipeline emptied. Channel rows need
//   no clearing: a row's contents are only used after an open has rewritten it.
module multichannel_slew_rate_limiter
    import mslr_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [2:0]                func,
    input  logic [2:0]                slot,
    input  logic signed [VALUE_W-1:0] operand,
    output logic                      done,
    output logic signed [VALUE_W-1:0] value,
    output logic [2:0]                opened_slot,
    output logic                      at_target,
    output logic [1:0]                status
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = (IW > 3) ? IW : 3;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    slot_row_t  row_mem [SLOTS];
    logic [SLOTS-1:0] in_use_reg, in_use_next;

    // stage 1
    logic                      s1_valid_reg;
    func_t                     s1_func_reg;
    logic                      s1_slot_ok_reg;
    logic [IW-1:0]             s1_idx_reg;
    logic signed [VALUE_W-1:0] s1_operand_reg;
    slot_row_t                 s1_row_reg;

    // result
    logic                      done_reg;
    logic signed [VALUE_W-1:0] value_reg,  value_next;
    logic [2:0]                opened_reg, opened_next;
    logic                      at_tgt_reg, at_tgt_next;
    status_t                   status_reg, status_next;

    // ---------------------------------------------------------------
    // Stage 1: decode and row read
    // ---------------------------------------------------------------
    logic          accept;
    logic [AW-1:0] slot_ext;
    logic          slot_ok;
    logic [IW-1:0] rd_idx;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    slot_row_t     wr_row;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign slot_ext = AW'(slot);
    assign slot_ok  = {29'd0, slot} < 32'(SLOTS);
    assign rd_idx   = slot_ok ? slot_ext[IW-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg    <= func_t'(func);
            s1_slot_ok_reg <= slot_ok;
            s1_idx_reg     <= rd_idx;
            s1_operand_reg <= operand;
            // row written by stage 2 at this edge is newer than the memory
            if (wr_en && (wr_idx == rd_idx))
            begin
                s1_row_reg <= wr_row;
            end
            else
            begin
                s1_row_reg <= row_mem[rd_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_idx] <= wr_row;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: free-slot search, operation, write back
    // ---------------------------------------------------------------
    logic                      free_found;
    logic [IW-1:0]             free_idx;
    logic [AW-1:0]             free_ext;
    logic                      used;
    logic signed [VALUE_W-1:0] ramp_cur;

    // lowest unused channel
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign free_ext = AW'(free_idx);
    assign used     = s1_slot_ok_reg && in_use_reg[s1_idx_reg];

    mslr_ramp u_ramp (
        .row      (s1_row_reg),
        .next_cur (ramp_cur)
    );

    always_comb
    begin
        in_use_next = in_use_reg;
        wr_en       = 1'b0;
        wr_idx      = s1_idx_reg;
        wr_row      = s1_row_reg;
        value_next  = '0;
        opened_next = 3'd0;
        at_tgt_next = 1'b1;
        status_next = STATUS_OK;

        if (s1_valid_reg)
        begin
            if (s1_func_reg == FUNC_OPEN)
            begin
                if (free_found)
                begin
                    in_use_next[free_idx] = 1'b1;
                    wr_en       = 1'b1;
                    wr_idx      = free_idx;
                    wr_row.cur  = '0;
                    wr_row.tgt  = '0;
                    wr_row.rate = RATE_W'(1);
                    opened_next = free_ext[2:0];
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            else if (!used)
            begin
                status_next = STATUS_UNUSED;
            end
            else
            begin
                case (s1_func_reg)
                    FUNC_CLOSE:
                    begin
                        in_use_next[s1_idx_reg] = 1'b0;
                    end
                    FUNC_SET_RATE:
                    begin
                        wr_en = 1'b1;
                        // rates below one clamp to one
                        if (s1_operand_reg[VALUE_W-1] || (s1_operand_reg == '0))
                        begin
                            wr_row.rate = RATE_W'(1);
                        end
                        else
                        begin
                            wr_row.rate = s1_operand_reg[RATE_W-1:0];
                        end
                    end
                    FUNC_SET_TARGET:
                    begin
                        wr_en      = 1'b1;
                        wr_row.tgt = s1_operand_reg;
                    end
                    FUNC_JUMP:
                    begin
                        wr_en      = 1'b1;
                        wr_row.cur = s1_operand_reg;
                        wr_row.tgt = s1_operand_reg;
                    end
                    FUNC_STEP:
                    begin
                        wr_en      = 1'b1;
                        wr_row.cur = ramp_cur;
                    end
                    default:
                    begin
                        // query, and the unassigned code, leave state alone
                    end
                endcase

                if (s1_func_reg != FUNC_CLOSE)
                begin
                    value_next  = wr_row.cur;
                    at_tgt_next = (wr_row.cur == wr_row.tgt);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            done_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            value_reg  <= value_next;
            opened_reg <= opened_next;
            at_tgt_reg <= at_tgt_next;
            status_reg <= status_next;
        end
    end

    assign done        = done_reg;
    assign value       = value_reg;
    assign opened_slot = opened_reg;
    assign at_target   = at_tgt_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // every request taken gives a result after the stage-1 and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("request taken without a result");

    // pool-full only when every channel was in use
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> $past(&in_use_reg))
        else $error("pool reported full with a free channel");

    // error results carry a zero value and report at target
    a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (at_target && (value == '0)))
        else $error("error result with non-zero value");

    // at most one channel opens per cycle
    a_one_open: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(in_use_reg) <= $past($countones(in_use_reg)) + 1)
        else $error("more than one channel opened at once");
`endif

endmodule
